>>> src/bounded_ordered_list_table_defines.svh
// ----------------------------------------------------------------------------
// Bounded ordered list table: assertion macros
// Shared property shapes used by the list table's checks.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_TABLE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BOLT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BOLT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bolt_pkg.sv
// ----------------------------------------------------------------------------
// Bounded ordered list table package
// Sizes, operation and status codes, controller states and cell controls.
// ----------------------------------------------------------------------------
`default_nettype none

package bolt_pkg;

    localparam int CAPACITY = 16;
    localparam int WORD_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 3;
    localparam int FOUND_W  = 4;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_FIND   = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_APPEND = 3'd4,
        OP_POP    = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_BADPOS   = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_EMPTY    = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Per-cell controls: load the request word, take the word from the cell
    // below (shift up) or take the word from the cell above (shift down).
    typedef struct packed {
        logic load;
        logic take_lower;
        logic take_upper;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> src/bounded_ordered_list_table.sv
// A word accepted on start is captured in the request registers and moves the controller
// to its execute state; the row of entry cells, the result registers and done are loaded
// from that state. A new word is not accepted until the execute state has ended.
// busy is high for the execute cycle only; start may be raised again while done shows.
// Reset clears the fill count and the controller; entries hold no reset value.
// The receiver cannot stall: done flags each result for exactly one cycle.
// ----------------------------------------------------------------------------
// Bounded ordered list table
// Fixed-capacity ordered list of signed words built as a row of entry cells.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bounded_ordered_list_table_defines.svh"

module bounded_ordered_list_table
    import bolt_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [OP_W-1:0]          operation,
    input  wire logic [POS_W-1:0]         position,
    input  wire logic signed [WORD_W-1:0] word_in,
    output logic                          done,
    output logic [STAT_W-1:0]             status,
    output logic signed [WORD_W-1:0]      word_out,
    output logic [FOUND_W-1:0]            found_at,
    output logic [CNT_W-1:0]              fill_count
);

    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [WORD_W-1:0] key_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              done_reg;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [WORD_W-1:0] rdata_reg, rdata_next;
    logic [FOUND_W-1:0] found_reg, found_next;

    cell_ctrl_t        ctrl [CAPACITY];
    logic [WORD_W-1:0] cell_word [CAPACITY];
    logic [CAPACITY-1:0] match;

    logic              accept;
    logic              exec;
    logic              ins_ok, del_ok, app_ok;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  hit_idx;
    logic              hit_any;

    assign accept = start && (state_reg == S_IDLE);
    assign exec   = (state_reg == S_EXEC);

    // Request validity, judged against the count held before the request.
    always_comb
    begin
        ins_ok = (op_reg == OP_INSERT) && ({1'b0, pos_reg} <= {1'b0, count_reg})
                 && (count_reg < CNT_W'(CAPACITY));
        del_ok = (op_reg == OP_DELETE) && ({1'b0, pos_reg} < {1'b0, count_reg});
        app_ok = (op_reg == OP_APPEND) && (count_reg < CNT_W'(CAPACITY));
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ctrl[i].load       = exec && ((ins_ok && (POS_W'(i) == pos_reg))
                                 || (app_ok && (CNT_W'(i) == count_reg)));
            ctrl[i].take_lower = exec && ins_ok && (POS_W'(i) > pos_reg)
                                 && (CNT_W'(i) <= count_reg);
            ctrl[i].take_upper = exec && del_ok && (POS_W'(i) >= pos_reg)
                                 && (CNT_W'(i + 1) < count_reg);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        bolt_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl[g]),
            .lower_word ((g == 0) ? '0 : cell_word[(g == 0) ? 0 : g - 1]),
            .upper_word ((g == CAPACITY - 1) ? '0
                         : cell_word[(g == CAPACITY - 1) ? g : g + 1]),
            .key        (key_reg),
            .word       (cell_word[g]),
            .match      (match[g])
        );
    end

    // Lowest held entry that matches the key.
    always_comb
    begin
        hit_idx = '0;
        hit_any = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match[i] && (CNT_W'(i) < count_reg))
            begin
                hit_idx = IDX_W'(i);
                hit_any = 1'b1;
            end
        end
    end

    // One read port: the popped entry or the addressed one.
    assign rd_addr = (op_reg == OP_POP) ? IDX_W'(count_reg - CNT_W'(1))
                                        : IDX_W'(pos_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = STAT_OK;
        rdata_next  = '0;
        found_next  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (op_reg)
                    OP_READ:
                    begin
                        if ({1'b0, pos_reg} >= {1'b0, count_reg})
                        begin
                            status_next = STAT_BADPOS;
                        end
                        else
                        begin
                            rdata_next = cell_word[rd_addr];
                        end
                    end
                    OP_FIND:
                    begin
                        if (hit_any)
                        begin
                            found_next = FOUND_W'(hit_idx);
                        end
                        else
                        begin
                            status_next = STAT_NOTFOUND;
                        end
                    end
                    OP_INSERT:
                    begin
                        if ({1'b0, pos_reg} > {1'b0, count_reg})
                        begin
                            status_next = STAT_BADPOS;
                        end
                        else if (!ins_ok)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_DELETE:
                    begin
                        if (!del_ok)
                        begin
                            status_next = STAT_BADPOS;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    OP_APPEND:
                    begin
                        if (!app_ok)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            rdata_next = cell_word[rd_addr];
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            pos_reg <= position;
            key_reg <= word_in;
        end
        if (exec)
        begin
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
            found_reg  <= found_next;
        end
    end

    assign busy       = exec;
    assign done       = done_reg;
    assign status     = status_reg;
    assign word_out   = rdata_reg;
    assign found_at   = found_reg;
    assign fill_count = count_reg;

    `BOLT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not start execution")
    `BOLT_ASSERT_NXT(a_exec_done, busy, done && !busy, "execution did not finish in one cycle")
    `BOLT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "fill count above capacity")
    `BOLT_ASSERT_IMP(a_full_count, done && (status == STAT_FULL), fill_count == CNT_W'(CAPACITY), "full reported below capacity")
    `BOLT_ASSERT_IMP(a_empty_count, done && (status == STAT_EMPTY), fill_count == '0 && word_out == '0, "empty pop with data or entries")

endmodule

`default_nettype wire

>>> src/bolt_cell.sv
// ----------------------------------------------------------------------------
// List entry cell
// Holds one entry, shifts with its neighbours and compares against the key.
// ----------------------------------------------------------------------------
`default_nettype none

module bolt_cell
    import bolt_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [WORD_W-1:0] lower_word,
    input  wire logic [WORD_W-1:0] upper_word,
    input  wire logic [WORD_W-1:0] key,
    output logic      [WORD_W-1:0] word,
    output logic                   match
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        priority if (ctrl.load)
        begin
            word_next = key;
        end
        else if (ctrl.take_lower)
        begin
            word_next = lower_word;
        end
        else if (ctrl.take_upper)
        begin
            word_next = upper_word;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word  = word_reg;
    assign match = (word_reg == key);

endmodule

`default_nettype wire
